[rtl/mss_pkg.sv]
package mss_pkg;

  localparam int SYMBOLS     = 256;
  localparam int COUNT_WIDTH = 24;

  localparam int SYM_AW     = $clog2(SYMBOLS);
  localparam int PAIR_DEPTH = SYMBOLS * 256;
  localparam int PAIR_AW    = SYM_AW + 8;
  localparam int SUM_W      = 32;
  localparam int RND_W      = 31;
  localparam int RUN_W      = (COUNT_WIDTH + 8 > RND_W) ? COUNT_WIDTH + 8 : RND_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]       SUM_MAX   = '1;
  localparam logic [8:0]             SYM_LIM   = 9'(SYMBOLS);
  localparam logic [7:0]             SYM_LAST  = 8'(SYMBOLS - 1);

  typedef logic [2:0] req_type_t;
  typedef logic [7:0] symbol_t;
  typedef logic [1:0] status_t;

  localparam req_type_t REQ_ADD_PAIR   = 3'd0;
  localparam req_type_t REQ_ADD_START  = 3'd1;
  localparam req_type_t REQ_FREEZE     = 3'd2;
  localparam req_type_t REQ_DRAW_NEXT  = 3'd3;
  localparam req_type_t REQ_DRAW_START = 3'd4;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_NO_SUCC = 2'd1;
  localparam status_t ST_RETRY   = 2'd2;

  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] start_cnt;
    logic [SUM_W-1:0]       frozen_tot;
    logic [SUM_W-1:0]       live_sum;
  } row_t;

endpackage

[rtl/mss_req_if.sv]
interface mss_req_if import mss_pkg::*; ();
  logic             valid;
  logic             ready;
  req_type_t        req_type;
  symbol_t          cur_symbol;
  symbol_t          next_symbol;
  logic [RND_W-1:0] random_value;

  modport source (output valid, req_type, cur_symbol, next_symbol, random_value,
                  input ready);
  modport sink (input valid, req_type, cur_symbol, next_symbol, random_value,
                output ready);
endinterface

[rtl/mss_rsp_if.sv]
interface mss_rsp_if import mss_pkg::*; ();
  logic    valid;
  logic    ready;
  symbol_t symbol;
  status_t status;

  modport source (output valid, symbol, status, input ready);
  modport sink (input valid, symbol, status, output ready);
endinterface

[rtl/mss_ram.sv]
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/mss_divmod.sv]
module mss_divmod import mss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [SUM_W-1:0] rem_o
);

  localparam int STEP_W = $clog2(RND_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RND_W-1:0]  dvd_q, dvd_d;
  logic [SUM_W-1:0]  dsr_q, dsr_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;

  assign trial = {rem_q, dvd_q[RND_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // restoring step: one quotient bit a cycle
      rem_d  = (trial >= {1'b0, dsr_q}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      dvd_d  = {dvd_q[RND_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(RND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/markov_symbol_sampler_core.sv]
// Byte-level Markov chain table with one result item per request item. After
// reset the block clears its pair-count memory, one entry a cycle, through all
// SYMBOLS*256 entries (65536 at 256 symbols), clearing the row memory along
// the way, and takes no item until then. Items are handled one at a time.
// Add transition reads, modifies and writes back the pair memory and the row
// memory; add start does so for the row memory only. Freeze walks the row
// memory, reading and then writing back each row. Draw start reads one row
// entry. Draw next: a bit-serial remainder unit reduces the random value
// modulo the frozen row total, then the row's pair counts stream out of the
// pair memory, one a cycle, until the running sum passes it; a zero row total
// answers without either step.
// The next request is taken while a finished result waits in the output register;
// a result that finds that register still full holds the block until it drains.
module markov_symbol_sampler_core import mss_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  mss_req_if.sink     req_i,
  mss_rsp_if.source   rsp_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RMW    = 4'd2;
  localparam logic [3:0] S_FRZ_RD = 4'd3;
  localparam logic [3:0] S_FRZ_WR = 4'd4;
  localparam logic [3:0] S_DN_ROW = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_DS_ROW = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]         state_q, state_d;
  req_type_t          kind_q, kind_d;
  symbol_t            cur_q, cur_d;
  symbol_t            nxt_q, nxt_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic [PAIR_AW-1:0] clr_q, clr_d;
  logic [SYM_AW-1:0]  fidx_q, fidx_d;
  logic [RND_W-1:0]   tgt_q, tgt_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [8:0]         scan_q, scan_d;
  logic               chk_v_q, chk_v_d;
  symbol_t            chk_idx_q, chk_idx_d;
  symbol_t            res_sym_q, res_sym_d;
  status_t            res_st_q, res_st_d;
  logic               out_v_q, out_v_d;
  symbol_t            out_sym_q;
  status_t            out_st_q;
  logic               load_out;

  logic                   pair_we;
  logic [PAIR_AW-1:0]     pair_addr;
  logic [COUNT_WIDTH-1:0] pair_wdata, pair_rdata;
  logic                   row_we;
  logic [SYM_AW-1:0]      row_addr;
  row_t                   row_wdata, row_rdata;

  div_req_t         div_req;
  logic             div_done;
  logic [SUM_W-1:0] div_rem;

  logic              cur_ok, nxt_ok;
  logic [RUN_W-1:0]  run_sum;
  logic [SYM_AW-1:0] ds_idx;

  mss_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .addr_i  (pair_addr),
    .wdata_i (pair_wdata),
    .rdata_o (pair_rdata)
  );

  mss_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (SYMBOLS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .addr_i  (row_addr),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata)
  );

  mss_divmod u_divmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  assign cur_ok  = {1'b0, req_i.cur_symbol} < SYM_LIM;
  assign nxt_ok  = {1'b0, req_i.next_symbol} < SYM_LIM;
  assign run_sum = run_q + RUN_W'(pair_rdata);
  // start trial index: random value mod SYMBOLS, a power of two
  assign ds_idx  = SYM_AW'(req_i.random_value % RND_W'(SYMBOLS));

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_v_q;
  assign rsp_o.symbol = out_sym_q;
  assign rsp_o.status = out_st_q;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    rnd_d      = rnd_q;
    clr_d      = clr_q;
    fidx_d     = fidx_q;
    tgt_d      = tgt_q;
    run_d      = run_q;
    scan_d     = scan_q;
    chk_v_d    = chk_v_q;
    chk_idx_d  = chk_idx_q;
    res_sym_d  = res_sym_q;
    res_st_d   = res_st_q;
    load_out   = 1'b0;
    pair_we    = 1'b0;
    pair_addr  = {cur_q[SYM_AW-1:0], nxt_q};
    pair_wdata = pair_rdata + 1'b1;
    row_we     = 1'b0;
    row_addr   = cur_q[SYM_AW-1:0];
    row_wdata  = row_rdata;
    div_req    = '0;

    unique case (state_q)
      S_CLEAR: begin
        pair_we    = 1'b1;
        pair_addr  = clr_q;
        pair_wdata = '0;
        if (clr_q < PAIR_AW'(SYMBOLS)) begin
          row_we    = 1'b1;
          row_addr  = clr_q[SYM_AW-1:0];
          row_wdata = '0;
        end
        if (clr_q == PAIR_AW'(PAIR_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        pair_addr = {req_i.cur_symbol[SYM_AW-1:0], req_i.next_symbol};
        row_addr  = req_i.cur_symbol[SYM_AW-1:0];
        if (req_i.valid) begin
          kind_d    = req_i.req_type;
          cur_d     = req_i.cur_symbol;
          nxt_d     = req_i.next_symbol;
          rnd_d     = req_i.random_value;
          res_sym_d = '0;
          res_st_d  = ST_DONE;
          unique case (req_i.req_type)
            REQ_ADD_PAIR:  state_d = (cur_ok && nxt_ok) ? S_RMW : S_DONE;
            REQ_ADD_START: state_d = cur_ok ? S_RMW : S_DONE;
            REQ_FREEZE: begin
              fidx_d  = '0;
              state_d = S_FRZ_RD;
            end
            REQ_DRAW_NEXT: begin
              if (cur_ok) begin
                state_d = S_DN_ROW;
              end else begin
                res_st_d = ST_NO_SUCC;
                state_d  = S_DONE;
              end
            end
            REQ_DRAW_START: begin
              row_addr  = ds_idx;
              res_sym_d = symbol_t'(ds_idx);
              state_d   = S_DS_ROW;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_RMW: begin
        if (kind_q == REQ_ADD_PAIR) begin
          // a saturated pair leaves the row sum alone
          if (pair_rdata != COUNT_MAX) begin
            pair_we = 1'b1;
            if (row_rdata.live_sum != SUM_MAX) begin
              row_we             = 1'b1;
              row_wdata.live_sum = row_rdata.live_sum + 1'b1;
            end
          end
        end else if (row_rdata.start_cnt != COUNT_MAX) begin
          row_we              = 1'b1;
          row_wdata.start_cnt = row_rdata.start_cnt + 1'b1;
        end
        state_d = S_DONE;
      end

      S_FRZ_RD: begin
        row_addr = fidx_q;
        state_d  = S_FRZ_WR;
      end

      S_FRZ_WR: begin
        row_addr             = fidx_q;
        row_we               = 1'b1;
        row_wdata.frozen_tot = row_rdata.live_sum;
        if (fidx_q == SYM_AW'(SYMBOLS - 1)) begin
          state_d = S_DONE;
        end else begin
          fidx_d  = fidx_q + 1'b1;
          state_d = S_FRZ_RD;
        end
      end

      S_DN_ROW: begin
        if (row_rdata.frozen_tot == '0) begin
          res_st_d = ST_NO_SUCC;
          state_d  = S_DONE;
        end else begin
          div_req = '{start: 1'b1, dividend: rnd_q, divisor: row_rdata.frozen_tot};
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          tgt_d   = div_rem[RND_W-1:0];
          scan_d  = '0;
          chk_v_d = 1'b0;
          run_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one read a cycle, check the count that arrives in the next cycle
        pair_addr = {cur_q[SYM_AW-1:0], scan_q[7:0]};
        if (scan_q < SYM_LIM) begin
          chk_v_d   = 1'b1;
          chk_idx_d = scan_q[7:0];
          scan_d    = scan_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
        end
        if (chk_v_q) begin
          run_d = run_sum;
          if (RUN_W'(tgt_q) < run_sum) begin
            res_sym_d = chk_idx_q;
            state_d   = S_DONE;
          end else if (chk_idx_q == SYM_LAST) begin
            res_st_d = ST_NO_SUCC;
            state_d  = S_DONE;
          end
        end
      end

      S_DS_ROW: begin
        if (row_rdata.start_cnt == '0) begin
          res_sym_d = '0;
          res_st_d  = ST_RETRY;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_v_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_v_d = (out_v_q && !rsp_o.ready) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      chk_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      chk_v_q <= chk_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    rnd_q     <= rnd_d;
    fidx_q    <= fidx_d;
    tgt_q     <= tgt_d;
    run_q     <= run_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    res_sym_q <= res_sym_d;
    res_st_q  <= res_st_d;
    if (load_out) begin
      out_sym_q <= res_sym_q;
      out_st_q  <= res_st_q;
    end
  end

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (!pair_we && !row_we))
    else $error("memory written during row scan");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("remainder unit finished outside its wait state");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_v_q || rsp_o.ready)) |=> (out_v_q && state_q == S_IDLE))
    else $error("finished item not moved to the output register");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_DONE) |-> (rsp_o.symbol == '0))
    else $error("flagged result carries a nonzero symbol");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_CLEAR && state_q != S_CLEAR) |->
      ($past(clr_q) == PAIR_AW'(PAIR_DEPTH - 1)))
    else $error("clearing pass left early");

endmodule
